// ===== rtl/i2cms_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cms_pkg
// Types, codes and the transition tables of the I2C master sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cms_pkg;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_EVENT = 2'd2;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_WR_RD = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [2:0] A_NONE   = 3'd0;
  localparam logic [2:0] A_START  = 3'd1;
  localparam logic [2:0] A_ADDR_W = 3'd2;
  localparam logic [2:0] A_ADDR_R = 3'd3;
  localparam logic [2:0] A_SEND   = 3'd4;
  localparam logic [2:0] A_RACK   = 3'd5;
  localparam logic [2:0] A_RNACK  = 3'd6;
  localparam logic [2:0] A_STOP   = 3'd7;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_START    = 4'd1;
  localparam logic [3:0] S_RESTART  = 4'd2;
  localparam logic [3:0] S_ADDRW    = 4'd3;
  localparam logic [3:0] S_ADDRR    = 4'd4;
  localparam logic [3:0] S_SENT     = 4'd5;
  localparam logic [3:0] S_LASTSENT = 4'd6;
  localparam logic [3:0] S_RECV     = 4'd7;
  localparam logic [3:0] S_LASTRECV = 4'd8;
  localparam logic [3:0] S_STOP     = 4'd9;

  localparam logic [7:0] ST_ILLEGAL  = 8'h00;
  localparam logic [7:0] ST_START    = 8'h08;
  localparam logic [7:0] ST_RESTART  = 8'h10;
  localparam logic [7:0] ST_AW_ACK   = 8'h18;
  localparam logic [7:0] ST_DATA_ACK = 8'h28;
  localparam logic [7:0] ST_AR_ACK   = 8'h40;
  localparam logic [7:0] ST_RX_ACK   = 8'h50;
  localparam logic [7:0] ST_RX_NACK  = 8'h58;
  localparam logic [7:0] ST_ANY      = 8'hff;
  localparam logic [7:0] STATUS_MASK = 8'hfc;

  localparam logic [1:0] RES_OK       = 2'd0;
  localparam logic [1:0] RES_MISMATCH = 2'd1;
  localparam logic [1:0] RES_ILLEGAL  = 2'd2;

  typedef struct packed {
    logic [3:0] ok_state;
    logic [2:0] ok_action;
    logic [3:0] err_state;
    logic [2:0] err_action;
    logic [7:0] expect_code;
  } row_t;

  typedef struct packed {
    logic [2:0] bus_action;
    logic [7:0] tx_byte;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [7:0] rx_byte;
    logic       done_res;
    logic [1:0] result_code;
    logic [7:0] err_bus_status;
    logic [3:0] err_seq_state;
  } res_t;

  function automatic row_t seq_row(input logic [1:0] sel, input logic [3:0] cur);
    row_t r;
    r = '{S_IDLE, A_NONE, S_IDLE, A_NONE, ST_ANY};
    unique case (sel)
      MODE_WRITE: begin
        unique case (cur)
          S_START:    r = '{S_ADDRW, A_ADDR_W, S_ADDRW, A_ADDR_W, ST_START};
          S_RESTART:  r = '{S_ADDRW, A_ADDR_W, S_ADDRW, A_ADDR_W, ST_RESTART};
          S_ADDRW:    r = '{S_SENT, A_SEND, S_STOP, A_STOP, ST_AW_ACK};
          S_SENT:     r = '{S_SENT, A_SEND, S_STOP, A_STOP, ST_DATA_ACK};
          S_LASTSENT: r = '{S_STOP, A_STOP, S_STOP, A_STOP, ST_DATA_ACK};
          S_ADDRR, S_RECV, S_LASTRECV:
                      r = '{S_STOP, A_STOP, S_STOP, A_STOP, ST_ILLEGAL};
          default:    r = '{S_IDLE, A_NONE, S_IDLE, A_NONE, ST_ANY};
        endcase
      end
      MODE_WR_RD: begin
        unique case (cur)
          S_START:    r = '{S_ADDRW, A_ADDR_W, S_ADDRW, A_ADDR_W, ST_START};
          S_RESTART:  r = '{S_ADDRR, A_ADDR_R, S_ADDRR, A_ADDR_R, ST_RESTART};
          S_ADDRW:    r = '{S_SENT, A_SEND, S_STOP, A_STOP, ST_AW_ACK};
          S_ADDRR:    r = '{S_RECV, A_RACK, S_STOP, A_STOP, ST_AR_ACK};
          S_SENT:     r = '{S_SENT, A_SEND, S_STOP, A_STOP, ST_DATA_ACK};
          S_LASTSENT: r = '{S_RESTART, A_START, S_STOP, A_STOP, ST_DATA_ACK};
          S_RECV:     r = '{S_RECV, A_RACK, S_STOP, A_STOP, ST_RX_ACK};
          S_LASTRECV: r = '{S_STOP, A_STOP, S_STOP, A_STOP, ST_RX_NACK};
          default:    r = '{S_IDLE, A_NONE, S_IDLE, A_NONE, ST_ANY};
        endcase
      end
      default: begin
        unique case (cur)
          S_START:    r = '{S_ADDRR, A_ADDR_R, S_ADDRR, A_ADDR_R, ST_START};
          S_RESTART:  r = '{S_ADDRR, A_ADDR_R, S_ADDRR, A_ADDR_R, ST_RESTART};
          S_ADDRR:    r = '{S_RECV, A_RACK, S_STOP, A_STOP, ST_AR_ACK};
          S_RECV:     r = '{S_RECV, A_RACK, S_STOP, A_STOP, ST_RX_ACK};
          S_LASTRECV: r = '{S_STOP, A_STOP, S_STOP, A_STOP, ST_RX_NACK};
          S_ADDRW, S_SENT, S_LASTSENT:
                      r = '{S_STOP, A_STOP, S_STOP, A_STOP, ST_ILLEGAL};
          default:    r = '{S_IDLE, A_NONE, S_IDLE, A_NONE, ST_ANY};
        endcase
      end
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/i2cms_in_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_in_if
// Input item channel of the I2C master sequencer: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [1:0] mode;
  logic [6:0] slave_addr;
  logic [7:0] send_last_index;
  logic [7:0] recv_last_index;
  logic [7:0] load_index;
  logic [7:0] load_byte;
  logic [7:0] bus_status;
  logic [7:0] bus_data;

  modport source (
    output valid, func, mode, slave_addr, send_last_index, recv_last_index,
           load_index, load_byte, bus_status, bus_data,
    input  ready
  );
  modport sink (
    input  valid, func, mode, slave_addr, send_last_index, recv_last_index,
           load_index, load_byte, bus_status, bus_data,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/i2cms_out_if.sv =====
// ----------------------------------------------------------------------------
// i2cms_out_if
// Result item channel of the I2C master sequencer: valid, ready and payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface i2cms_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] bus_action;
  logic [7:0] tx_byte;
  logic       rx_valid;
  logic [7:0] rx_index;
  logic [7:0] rx_byte;
  logic       done_res;
  logic [1:0] result_code;
  logic [7:0] err_bus_status;
  logic [3:0] err_seq_state;

  modport source (
    output valid, bus_action, tx_byte, rx_valid, rx_index, rx_byte, done_res,
           result_code, err_bus_status, err_seq_state,
    input  ready
  );
  modport sink (
    input  valid, bus_action, tx_byte, rx_valid, rx_index, rx_byte, done_res,
           result_code, err_bus_status, err_seq_state,
    output ready
  );
endinterface

`default_nettype wire

// ===== rtl/i2cms_ram.sv =====
// ----------------------------------------------------------------------------
// i2cms_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/i2c_master_transfer_sequencer_core.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_core
// I2C master transfer sequencer stepped by two-wire bus status codes.
// ----------------------------------------------------------------------------
// Each item has an accept cycle, where a load item writes the send byte
// store and the store is read at the current send position, and then an
// execute cycle, where the registered store data, the mode table and the
// sequence registers produce the result and the next state. One item is in
// work at a time: a new item is accepted only after the last one has
// executed, and a result held by a stalled output delays the execute cycle
// until taken. The send store is not cleared after reset: entries are to be
// read only after a load has written them; the block does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_transfer_sequencer_core #(
  parameter int SEND_DEPTH = 256
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  i2cms_in_if.sink   in_ch,
  i2cms_out_if.source out_ch
);

  localparam int AW = $clog2(SEND_DEPTH);

  logic            busy_r,  busy_nxt;
  logic            out_valid_r, out_valid_nxt;
  i2cms_pkg::res_t res_r, res_nxt;

  logic [1:0] it_func_r;
  logic [1:0] it_mode_r;
  logic [6:0] it_addr_r;
  logic [7:0] it_slast_r;
  logic [7:0] it_rlast_r;
  logic [7:0] it_status_r;
  logic [7:0] it_data_r;

  logic          active_r,   active_nxt;
  logic [1:0]    tsel_r,     tsel_nxt;
  logic [3:0]    seq_r,      seq_nxt;
  logic [6:0]    taddr_r,    taddr_nxt;
  logic [7:0]    spos_r,     spos_nxt;
  logic [AW-1:0] saddr_r,    saddr_nxt;
  logic [7:0]    slast_r,    slast_nxt;
  logic [7:0]    rpos_r,     rpos_nxt;
  logic [7:0]    rlast_r,    rlast_nxt;
  logic [1:0]    outcome_r,  outcome_nxt;
  logic [7:0]    fstatus_r,  fstatus_nxt;
  logic [3:0]    fstate_r,   fstate_nxt;

  logic          in_acc;
  logic          exec;
  logic          ram_we;
  logic [7:0]    ram_rdata;

  assign in_ch.ready = !busy_r;
  assign in_acc      = in_ch.valid && !busy_r;
  assign exec        = busy_r && (!out_valid_r || out_ch.ready);
  assign ram_we      = in_acc && (in_ch.func == i2cms_pkg::FUNC_LOAD)
                       && ({1'b0, in_ch.load_index} < 9'(SEND_DEPTH));

  i2cms_ram #(
    .WIDTH (8),
    .DEPTH (SEND_DEPTH)
  ) u_send_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ch.load_index[AW-1:0]),
    .wdata (in_ch.load_byte),
    .raddr (saddr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    i2cms_pkg::row_t row;
    logic [1:0] sel;
    logic [3:0] cur;
    logic [7:0] masked;
    logic [2:0] action;
    logic [3:0] nxt;

    busy_nxt      = busy_r;
    out_valid_nxt = out_valid_r;
    res_nxt       = res_r;
    active_nxt    = active_r;
    tsel_nxt      = tsel_r;
    seq_nxt       = seq_r;
    taddr_nxt     = taddr_r;
    spos_nxt      = spos_r;
    saddr_nxt     = saddr_r;
    slast_nxt     = slast_r;
    rpos_nxt      = rpos_r;
    rlast_nxt     = rlast_r;
    outcome_nxt   = outcome_r;
    fstatus_nxt   = fstatus_r;
    fstate_nxt    = fstate_r;

    sel    = (tsel_r > i2cms_pkg::MODE_READ) ? i2cms_pkg::MODE_READ : tsel_r;
    cur    = (seq_r > i2cms_pkg::S_STOP) ? i2cms_pkg::S_STOP : seq_r;
    masked = it_status_r & i2cms_pkg::STATUS_MASK;
    row    = i2cms_pkg::seq_row(sel, cur);
    action = i2cms_pkg::A_NONE;
    nxt    = seq_r;

    if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      busy_nxt = 1'b1;
    end

    if (exec) begin
      busy_nxt      = 1'b0;
      out_valid_nxt = 1'b1;
      res_nxt       = '0;
      unique case (it_func_r)
        i2cms_pkg::FUNC_START: begin
          if (!active_r && it_mode_r <= i2cms_pkg::MODE_READ) begin
            active_nxt         = 1'b1;
            tsel_nxt           = it_mode_r;
            seq_nxt            = i2cms_pkg::S_START;
            taddr_nxt          = it_addr_r;
            spos_nxt           = '0;
            saddr_nxt          = '0;
            slast_nxt          = it_slast_r;
            rpos_nxt           = '0;
            rlast_nxt          = it_rlast_r;
            outcome_nxt        = i2cms_pkg::RES_OK;
            fstatus_nxt        = '0;
            fstate_nxt         = '0;
            res_nxt.bus_action = i2cms_pkg::A_START;
          end
        end
        i2cms_pkg::FUNC_EVENT: begin
          if (!active_r) begin
            seq_nxt = i2cms_pkg::S_IDLE;
          end else begin
            if (cur == i2cms_pkg::S_RECV || cur == i2cms_pkg::S_LASTRECV) begin
              res_nxt.rx_valid = 1'b1;
              res_nxt.rx_index = rpos_r;
              res_nxt.rx_byte  = it_data_r;
              rpos_nxt         = rpos_r + 8'd1;
            end
            if (row.expect_code == i2cms_pkg::ST_ILLEGAL) begin
              outcome_nxt = i2cms_pkg::RES_ILLEGAL;
              fstate_nxt  = cur;
              nxt         = row.err_state;
              action      = row.err_action;
            end else if (row.expect_code == i2cms_pkg::ST_ANY
                         || row.expect_code == masked) begin
              nxt    = row.ok_state;
              action = row.ok_action;
            end else begin
              outcome_nxt = i2cms_pkg::RES_MISMATCH;
              fstate_nxt  = cur;
              fstatus_nxt = masked;
              nxt         = row.err_state;
              action      = row.err_action;
            end
            if (action == i2cms_pkg::A_RACK && rpos_nxt == rlast_r) begin
              action = i2cms_pkg::A_RNACK;
              nxt    = i2cms_pkg::S_LASTRECV;
            end
            res_nxt.bus_action = action;
            unique case (action)
              i2cms_pkg::A_NONE: active_nxt = 1'b0;
              i2cms_pkg::A_ADDR_W: res_nxt.tx_byte = {taddr_r, 1'b0};
              i2cms_pkg::A_ADDR_R: res_nxt.tx_byte = {taddr_r, 1'b1};
              i2cms_pkg::A_SEND: begin
                res_nxt.tx_byte = ram_rdata;
                if (spos_r == slast_r) begin
                  nxt = i2cms_pkg::S_LASTSENT;
                end else begin
                  spos_nxt = spos_r + 8'd1;
                  if (spos_r == 8'hff || saddr_r == AW'(SEND_DEPTH - 1)) begin
                    saddr_nxt = '0;
                  end else begin
                    saddr_nxt = saddr_r + AW'(1);
                  end
                end
              end
              i2cms_pkg::A_STOP: begin
                res_nxt.done_res       = 1'b1;
                res_nxt.result_code    = outcome_nxt;
                res_nxt.err_bus_status = fstatus_nxt;
                res_nxt.err_seq_state  = fstate_nxt;
              end
              default: ;
            endcase
            seq_nxt = nxt;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
      active_r    <= 1'b0;
      tsel_r      <= '0;
      seq_r       <= i2cms_pkg::S_IDLE;
      taddr_r     <= '0;
      spos_r      <= '0;
      saddr_r     <= '0;
      slast_r     <= '0;
      rpos_r      <= '0;
      rlast_r     <= '0;
      outcome_r   <= i2cms_pkg::RES_OK;
      fstatus_r   <= '0;
      fstate_r    <= '0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      active_r    <= active_nxt;
      tsel_r      <= tsel_nxt;
      seq_r       <= seq_nxt;
      taddr_r     <= taddr_nxt;
      spos_r      <= spos_nxt;
      saddr_r     <= saddr_nxt;
      slast_r     <= slast_nxt;
      rpos_r      <= rpos_nxt;
      rlast_r     <= rlast_nxt;
      outcome_r   <= outcome_nxt;
      fstatus_r   <= fstatus_nxt;
      fstate_r    <= fstate_nxt;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (in_acc) begin
      it_func_r   <= in_ch.func;
      it_mode_r   <= in_ch.mode;
      it_addr_r   <= in_ch.slave_addr;
      it_slast_r  <= in_ch.send_last_index;
      it_rlast_r  <= in_ch.recv_last_index;
      it_status_r <= in_ch.bus_status;
      it_data_r   <= in_ch.bus_data;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.bus_action     = res_r.bus_action;
  assign out_ch.tx_byte        = res_r.tx_byte;
  assign out_ch.rx_valid       = res_r.rx_valid;
  assign out_ch.rx_index       = res_r.rx_index;
  assign out_ch.rx_byte        = res_r.rx_byte;
  assign out_ch.done_res       = res_r.done_res;
  assign out_ch.result_code    = res_r.result_code;
  assign out_ch.err_bus_status = res_r.err_bus_status;
  assign out_ch.err_seq_state  = res_r.err_seq_state;

endmodule

`default_nettype wire

// ===== rtl/i2cms_checker.sv =====
// ----------------------------------------------------------------------------
// i2cms_checker
// Port-level checks of the I2C master sequencer result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cms_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] bus_action,
  input wire logic [7:0] tx_byte,
  input wire logic       rx_valid,
  input wire logic       done_res,
  input wire logic [1:0] result_code,
  input wire logic [7:0] err_bus_status,
  input wire logic [3:0] err_seq_state
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(bus_action) && $stable(tx_byte))
    else $error("result item changed while stalled");

  a_done_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (done_res == (bus_action == i2cms_pkg::A_STOP)))
    else $error("done flag does not match stop action");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !done_res |-> result_code == i2cms_pkg::RES_OK && err_bus_status == 8'd0
                               && err_seq_state == i2cms_pkg::S_IDLE)
    else $error("error report outside stop");

  a_rx_action: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && rx_valid |-> bus_action == i2cms_pkg::A_RACK
                              || bus_action == i2cms_pkg::A_RNACK
                              || bus_action == i2cms_pkg::A_STOP)
    else $error("received byte with unexpected bus action");

  a_tx_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && bus_action != i2cms_pkg::A_ADDR_W && bus_action != i2cms_pkg::A_ADDR_R
      && bus_action != i2cms_pkg::A_SEND |-> tx_byte == 8'd0)
    else $error("transmit byte without address or send action");

endmodule

bind i2c_master_transfer_sequencer_core i2cms_checker u_i2cms_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .bus_action     (out_ch.bus_action),
  .tx_byte        (out_ch.tx_byte),
  .rx_valid       (out_ch.rx_valid),
  .done_res       (out_ch.done_res),
  .result_code    (out_ch.result_code),
  .err_bus_status (out_ch.err_bus_status),
  .err_seq_state  (out_ch.err_seq_state)
);

`default_nettype wire
